[rtl/jse_pkg.sv]
// Shared types and constants for the JSON string escaper.
package jse_pkg;

   localparam int unsigned CAP_W = 16;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd64;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U = 8'h75;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [CAP_W-1:0] MIN_CAPACITY = 16'd3;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_PLAIN,
      JOB_PAIR,
      JOB_CTRL,
      JOB_END,
      JOB_EMPTY
   } kind_type;

   typedef struct packed {
      logic       open_quote;
      kind_type   kind;
      logic [7:0] char;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/jse_req_if.sv]
// Input channel: one text byte per beat.
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

[rtl/jse_rsp_if.sv]
// Result channel: one escaped output byte per beat.
interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_string;
   logic       nothing_written;

   modport source (output valid, output out_byte, output last_of_string,
                   output nothing_written, input ready);
   modport sink (input valid, input out_byte, input last_of_string,
                 input nothing_written, output ready);
endinterface

[rtl/jse_front.sv]
// Front end: accepts text bytes, runs room checks and queues escape jobs.
module jse_front (
   input  logic                        clock,
   input  logic                        reset,
   jse_req_if.sink                     req_bus,
   input  logic                        csr_write_en,
   input  logic [jse_pkg::CAP_W-1:0]   csr_write_data,
   input  jse_pkg::queue_status_type   queue_status,
   output logic                        push,
   output jse_pkg::job_type            push_job
);
   import jse_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] bytes_used_ff, bytes_used_in;
   logic             quote_opened_ff, quote_opened_in;
   logic             truncated_ff, truncated_in;

   logic             accept;
   logic [CAP_W-1:0] used;
   logic [CAP_W:0]   used_wide;
   logic [CAP_W:0]   cap_wide;
   logic [7:0]       v;
   job_type          job;

   assign req_bus.ready = !queue_status.full;
   assign accept = req_bus.valid && req_bus.ready;
   assign v = req_bus.text_byte;

   assign capacity_in = csr_write_en ? csr_write_data : capacity_ff;

   always_comb begin
      used = quote_opened_ff ? bytes_used_ff : CAP_W'(1);
      used_wide = {1'b0, used};
      cap_wide = {1'b0, capacity_ff};
      bytes_used_in = bytes_used_ff;
      quote_opened_in = quote_opened_ff;
      truncated_in = truncated_ff;
      job.open_quote = 1'b0;
      job.kind = JOB_NONE;
      job.char = v;
      if (capacity_ff < MIN_CAPACITY) begin
         if (v == CHAR_NUL) begin
            job.kind = JOB_EMPTY;
            bytes_used_in = '0;
            quote_opened_in = 1'b0;
            truncated_in = 1'b0;
         end
      end else begin
         job.open_quote = !quote_opened_ff;
         quote_opened_in = 1'b1;
         bytes_used_in = used;
         if (v == CHAR_NUL) begin
            job.kind = JOB_END;
            bytes_used_in = '0;
            quote_opened_in = 1'b0;
            truncated_in = 1'b0;
         end else if (truncated_ff) begin
            job.kind = JOB_NONE;
         end else if (used_wide + (CAP_W+1)'(2) >= cap_wide) begin
            truncated_in = 1'b1;
         end else if (v == CHAR_QUOTE || v == CHAR_BACKSLASH) begin
            if (used_wide + (CAP_W+1)'(3) >= cap_wide) begin
               truncated_in = 1'b1;
            end else begin
               job.kind = JOB_PAIR;
               bytes_used_in = used + CAP_W'(2);
            end
         end else if (v < CTRL_LIMIT) begin
            if (used_wide + (CAP_W+1)'(7) >= cap_wide) begin
               truncated_in = 1'b1;
            end else begin
               job.kind = JOB_CTRL;
               bytes_used_in = used + CAP_W'(6);
            end
         end else begin
            job.kind = JOB_PLAIN;
            bytes_used_in = used + CAP_W'(1);
         end
      end
   end

   assign push = accept && (job.open_quote || job.kind != JOB_NONE);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         bytes_used_ff <= '0;
         quote_opened_ff <= 1'b0;
         truncated_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         if (accept) begin
            bytes_used_ff <= bytes_used_in;
            quote_opened_ff <= quote_opened_in;
            truncated_ff <= truncated_in;
         end
      end
   end

   a_trunc_needs_quote: assert property (@(posedge clock) disable iff (reset)
      truncated_ff |-> quote_opened_ff)
      else $error("truncated set without an open string");

endmodule

[rtl/jse_queue.sv]
// Short job queue between the front end and the output sequencer.
module jse_queue #(
   parameter int unsigned DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  jse_pkg::job_type            push_job,
   input  logic                        pop,
   output jse_pkg::job_type            head_job,
   output jse_pkg::queue_status_type   status
);
   import jse_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full job queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty job queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue count out of range");

endmodule

[rtl/jse_back.sv]
// Back end: expands queued jobs into output bytes, one per cycle while the sink is ready.
module jse_back (
   input  logic                        clock,
   input  logic                        reset,
   input  jse_pkg::job_type            head_job,
   input  jse_pkg::queue_status_type   queue_status,
   output logic                        pop,
   jse_rsp_if.source                   rsp_bus
);
   import jse_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       empty_ff, empty_in;

   logic [2:0] job_len;
   logic [2:0] kind_len;
   logic [2:0] k;
   logic       load;

   always_comb begin
      case (head_job.kind)
         JOB_PLAIN: kind_len = 3'd1;
         JOB_PAIR:  kind_len = 3'd2;
         JOB_CTRL:  kind_len = 3'd6;
         JOB_END:   kind_len = 3'd2;
         JOB_EMPTY: kind_len = 3'd1;
         default:   kind_len = 3'd0;
      endcase
      job_len = kind_len + {2'b00, head_job.open_quote};
      k = step_ff - {2'b00, head_job.open_quote};
   end

   // Pick the byte for the current step of the head job.
   always_comb begin
      byte_in = CHAR_NUL;
      last_in = 1'b0;
      empty_in = 1'b0;
      if (head_job.open_quote && step_ff == 3'd0) begin
         byte_in = CHAR_QUOTE;
      end else begin
         case (head_job.kind)
            JOB_PLAIN: byte_in = head_job.char;
            JOB_PAIR:  byte_in = (k == 3'd0) ? CHAR_BACKSLASH : head_job.char;
            JOB_CTRL: begin
               case (k)
                  3'd0:    byte_in = CHAR_BACKSLASH;
                  3'd1:    byte_in = CHAR_U;
                  3'd2:    byte_in = CHAR_ZERO;
                  3'd3:    byte_in = CHAR_ZERO;
                  3'd4:    byte_in = HEX_DIGITS[head_job.char[7:4]];
                  default: byte_in = HEX_DIGITS[head_job.char[3:0]];
               endcase
            end
            JOB_END: begin
               if (k == 3'd0) begin
                  byte_in = CHAR_QUOTE;
               end else begin
                  byte_in = CHAR_NUL;
                  last_in = 1'b1;
               end
            end
            JOB_EMPTY: begin
               byte_in = CHAR_NUL;
               last_in = 1'b1;
               empty_in = 1'b1;
            end
            default: byte_in = CHAR_NUL;
         endcase
      end
   end

   assign load = !queue_status.empty && (!valid_ff || rsp_bus.ready);
   assign pop = load && (step_ff == job_len - 3'd1);

   always_comb begin
      step_in = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in = pop ? 3'd0 : step_ff + 3'd1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the payload while the sink stalls.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         empty_ff <= empty_in;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.out_byte = byte_ff;
   assign rsp_bus.last_of_string = last_ff;
   assign rsp_bus.nothing_written = empty_ff;

   a_step_in_job: assert property (@(posedge clock) disable iff (reset)
      !queue_status.empty |-> step_ff < job_len)
      else $error("output step beyond length of head job");

   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> step_ff == 3'd0)
      else $error("step counter not cleared with empty queue");

endmodule

[rtl/json_string_escaper.sv]
// Top level of the JSON string escaper: front end, job queue and output sequencer.
//
//   channel   dir   handshake           payload
//   req_bus   in    valid/ready         text_byte[7:0]
//   rsp_bus   out   valid/ready         out_byte[7:0], last_of_string, nothing_written
//   csr_*     in    csr_write_en        csr_write_data[15:0] (output_capacity)
//
// The front end takes one text byte per cycle while the job queue has room;
// each byte that yields output becomes one queued job, a dropped byte none.
// The output sequencer emits one byte per cycle while rsp_bus is ready, so a job
// yields 1 to 7 bytes there (opening quote plus up to six escape bytes); the sustained
// rate is set by that single output byte lane.
// The first result beat of a byte passes through the job queue and the output
// register before it is valid on rsp_bus.
// Reset is synchronous: capacity returns to 64 and the queue empties.
// A stalled rsp_bus fills the queue, and then req_bus.ready drops.
module json_string_escaper #(
   parameter int unsigned QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   jse_req_if.sink                     req_bus,
   jse_rsp_if.source                   rsp_bus,
   input  logic                        csr_write_en,
   input  logic [jse_pkg::CAP_W-1:0]   csr_write_data
);
   import jse_pkg::*;

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type queue_status;

   jse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_status   (queue_status),
      .push           (push),
      .push_job       (push_job)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule
